// ----- hw/rtl/olist_pkg.sv -----
// olist_pkg: shared types and constants for the ordered list block
// operation and status codes, controller states, default sizes
// no dependencies
package olist_pkg;

  // default sizes, overridable on the top level
  localparam int CAPACITY_DEF   = 16;
  localparam int VALUE_BITS_DEF = 32;

  // fixed field widths of the command and result ports
  localparam int OP_W  = 2;
  localparam int KEY_W = 32;
  localparam int POS_W = 4;
  localparam int CNT_W = 5;
  localparam int STS_W = 2;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2
  } op_e;

  // status codes
  typedef enum logic [STS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_MISSING = 2'd1,
    STAT_FULL    = 2'd2
  } status_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT
  } state_e;

endpackage

// ----- hw/rtl/ordered_list_insert_delete_search.sv -----
// ordered list, newest at head, held as a ring in a synchronous ram
// insert or unknown op: result in the cycle after the request; search: scan from the head,
// one entry compared per cycle through the single ram read port; delete: scan to the match,
// then the entries behind it move up one per cycle
// one transaction at a time, busy high from a search or delete until its result strobe; results cannot be stalled
// reset empties the list at once (count and head cleared), ram contents are left as they are
module ordered_list_insert_delete_search #(
  parameter int CAPACITY   = olist_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = olist_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [olist_pkg::OP_W-1:0]      op_i,
  input  logic signed [olist_pkg::KEY_W-1:0] key_i,
  output logic                            result_valid_o,
  output logic [olist_pkg::STS_W-1:0]     status_o,
  output logic [olist_pkg::POS_W-1:0]     position_o,
  output logic [olist_pkg::CNT_W-1:0]     entry_count_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // physical slot of a logical index, ring starting at the head
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [AW-1:0] idx);
    logic [AW:0] sum;
    sum = {1'b0, head} + {1'b0, idx};
    if (sum >= (AW+1)'(CAPACITY)) begin
      sum = sum - (AW+1)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  olist_pkg::state_e  state_q, state_d;
  olist_pkg::status_e stat_q, stat_d;

  logic [VALUE_BITS-1:0] key_q, key_d;
  logic                  is_del_q, is_del_d;
  logic [AW-1:0]         head_q, head_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         nxt_q, nxt_d;
  logic [CW-1:0]         rd_idx_q, rd_idx_d;
  logic                  pend_q, pend_d;
  logic [CW-1:0]         wr_q, wr_d;
  logic [CW-1:0]         pos_q, pos_d;
  logic                  vld_q, vld_d;

  logic                  accept;
  logic signed [63:0]    key_ext;
  logic [VALUE_BITS-1:0] key_val;
  logic                  match;
  logic                  last;
  logic                  shift_end;
  logic [AW-1:0]         new_head;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;

  logic [31:0]           pos_ext;
  logic [31:0]           cnt_ext;

  // entry store
  olist_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // handshake and key sizing
  assign busy    = (state_q != olist_pkg::ST_IDLE);
  assign accept  = start && !busy;
  assign key_ext = 64'(key_i);
  assign key_val = key_ext[VALUE_BITS-1:0];

  // scan and shift conditions
  assign match     = pend_q && (ram_rdata == key_q);
  assign last      = pend_q && (rd_idx_q == (count_q - CW'(1)));
  assign shift_end = !pend_q && (nxt_q >= count_q);
  assign new_head  = (head_q == '0) ? AW'(CAPACITY - 1) : (head_q - AW'(1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      olist_pkg::ST_IDLE: begin
        if (accept && ((op_i == olist_pkg::OP_DELETE) ||
                       (op_i == olist_pkg::OP_SEARCH))) begin
          state_d = olist_pkg::ST_SCAN;
        end
      end
      olist_pkg::ST_SCAN: begin
        if (match) begin
          state_d = is_del_q ? olist_pkg::ST_SHIFT : olist_pkg::ST_IDLE;
        end else if ((count_q == '0) || last) begin
          state_d = olist_pkg::ST_IDLE;
        end
      end
      olist_pkg::ST_SHIFT: begin
        if (shift_end) begin
          state_d = olist_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = olist_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath, ram control and result
  always_comb begin
    key_d     = key_q;
    is_del_d  = is_del_q;
    head_d    = head_q;
    count_d   = count_q;
    nxt_d     = nxt_q;
    rd_idx_d  = rd_idx_q;
    pend_d    = pend_q;
    wr_d      = wr_q;
    pos_d     = pos_q;
    stat_d    = stat_q;
    vld_d     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = slot_of(head_q, wr_q[AW-1:0]);
    ram_wdata = ram_rdata;
    ram_raddr = slot_of(head_q, nxt_q[AW-1:0]);
    case (state_q)
      olist_pkg::ST_IDLE: begin
        if (accept) begin
          case (op_i)
            olist_pkg::OP_INSERT: begin
              vld_d = 1'b1;
              pos_d = '0;
              if (count_q >= CW'(CAPACITY)) begin
                stat_d = olist_pkg::STAT_FULL;
              end else begin
                stat_d    = olist_pkg::STAT_OK;
                head_d    = new_head;
                count_d   = count_q + CW'(1);
                ram_we    = 1'b1;
                ram_waddr = new_head;
                ram_wdata = key_val;
              end
            end
            olist_pkg::OP_DELETE, olist_pkg::OP_SEARCH: begin
              key_d    = key_val;
              is_del_d = (op_i == olist_pkg::OP_DELETE);
              nxt_d    = '0;
              pend_d   = 1'b0;
            end
            default: begin
              vld_d  = 1'b1;
              stat_d = olist_pkg::STAT_MISSING;
              pos_d  = '0;
            end
          endcase
        end
      end
      olist_pkg::ST_SCAN: begin
        if (match) begin
          pos_d  = rd_idx_q;
          pend_d = 1'b0;
          if (is_del_q) begin
            wr_d  = rd_idx_q;
            nxt_d = rd_idx_q + CW'(1);
          end else begin
            vld_d  = 1'b1;
            stat_d = olist_pkg::STAT_OK;
          end
        end else if ((count_q == '0) || last) begin
          vld_d  = 1'b1;
          stat_d = olist_pkg::STAT_MISSING;
          pos_d  = '0;
          pend_d = 1'b0;
        end else begin
          // issue the read of the next entry
          pend_d   = 1'b1;
          rd_idx_d = nxt_q;
          nxt_d    = nxt_q + CW'(1);
        end
      end
      olist_pkg::ST_SHIFT: begin
        // move the entry read last cycle one place towards the head
        if (pend_q) begin
          ram_we = 1'b1;
          wr_d   = wr_q + CW'(1);
        end
        if (nxt_q < count_q) begin
          pend_d = 1'b1;
          nxt_d  = nxt_q + CW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            count_d = count_q - CW'(1);
            vld_d   = 1'b1;
            stat_d  = olist_pkg::STAT_OK;
          end
        end
      end
      default: begin
        pend_d = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= olist_pkg::ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
      pend_q  <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      vld_q   <= vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    is_del_q <= is_del_d;
    nxt_q    <= nxt_d;
    rd_idx_q <= rd_idx_d;
    wr_q     <= wr_d;
    pos_q    <= pos_d;
    stat_q   <= stat_d;
  end

  // result ports
  assign pos_ext        = 32'(pos_q);
  assign cnt_ext        = 32'(count_q);
  assign result_valid_o = vld_q;
  assign status_o       = stat_q;
  assign position_o     = pos_ext[olist_pkg::POS_W-1:0];
  assign entry_count_o  = cnt_ext[olist_pkg::CNT_W-1:0];

endmodule

// ----- hw/rtl/olist_ram.sv -----
// olist_ram: entry store, one write port and one registered read port
// plain array, no reset; read data appears in the cycle after the address
// no dependencies
module olist_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
